@@ hdl/bpfl_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfl_pkg: shared types and constants of the byte pattern finder
// Field widths, register indexes, the queue item and the configuration bundle.
// ----------------------------------------------------------------------------
package bpfl_pkg;

  localparam int DATA_W  = 8;
  localparam int LINE_W  = 32;
  localparam int COL_W   = 24;
  localparam int INDEX_W = 25;
  localparam int LEN_W   = 5;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 5;

  localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [LINE_W-1:0] LINE_MAX     = 32'hFFFF_FFFF;
  localparam logic [COL_W-1:0]  COL_MAX      = 24'hFF_FFFF;

  // Decoupling queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QIDX_W = 1;

  // Register indexes, taken from cfg_paddr[4:3].
  localparam logic [1:0] REG_PAT_LO  = 2'd0;
  localparam logic [1:0] REG_PAT_HI  = 2'd1;
  localparam logic [1:0] REG_PAT_LEN = 2'd2;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_SHORT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              is_newline;
    logic              last;
  } bpfl_item_t;

  typedef struct packed {
    logic [CFG_DW-1:0] pat_lo;
    logic [CFG_DW-1:0] pat_hi;
    logic [LEN_W-1:0]  pat_len;
  } bpfl_cfg_t;

endpackage

@@ hdl/bpfl_front.sv @@
// ----------------------------------------------------------------------------
// bpfl_front: input side of the pattern finder
// Accepts beats, classifies newlines and holds them in a short queue.
// ----------------------------------------------------------------------------
module bpfl_front import bpfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_last,
  output logic              q_valid,
  input  logic              q_ready,
  output bpfl_item_t        q_item
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  bpfl_item_t             mem_r [QDEPTH];
  logic [QIDX_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   push, pop;
  bpfl_item_t             item_in;

  assign in_ready = (count_r != CNT_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    item_in.data_byte  = in_byte;
    item_in.is_newline = (in_byte == NEWLINE_BYTE);
    item_in.last       = in_last;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

@@ hdl/bpfl_back.sv @@
// ----------------------------------------------------------------------------
// bpfl_back: execution side of the pattern finder
// Tracks line and column, shifts the window, compares and registers results.
// ----------------------------------------------------------------------------
module bpfl_back import bpfl_pkg::*; #(
  parameter int MAX_PATTERN = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpfl_cfg_t          cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  bpfl_item_t         q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [LINE_W-1:0]  out_line,
  output logic [INDEX_W-1:0] out_index
);

  localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [DATA_W-1:0]     win_r   [MAX_PATTERN];
  logic [DATA_W-1:0]     win_nxt [MAX_PATTERN];
  logic [LEN_W-1:0]      filled_r, filled_nxt;
  logic [LINE_W-1:0]     line_r, line_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [LINE_W-1:0]     out_line_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic [LEN_W-1:0]      eff_len;
  logic [2*CFG_DW-1:0]   pattern;
  logic                  window_match;
  logic                  hit, too_short;
  logic                  take;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_ready   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_line  = out_line_r;
  assign out_index = out_index_r;
  assign pattern   = {cfg.pat_hi, cfg.pat_lo};

  always_comb begin
    if (cfg.pat_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.pat_len > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = cfg.pat_len;
    end
  end

  // Line and column counters saturate at their top values.
  always_comb begin
    if (q_item.is_newline) begin
      line_nxt = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
      col_nxt  = COL_W'(1);
    end else begin
      line_nxt = line_r;
      col_nxt  = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
    end
    filled_nxt = (filled_r == LEN_W'(MAX_PATTERN)) ? filled_r : filled_r + 1'b1;
  end

  always_comb begin
    win_nxt[0] = q_item.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // Pattern byte i is held against the byte that arrived len-1-i beats ago.
  always_comb begin
    logic [LEN_W-1:0] age;
    window_match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      age = eff_len - LEN_W'(i) - LEN_W'(1);
      if (LEN_W'(i) < eff_len) begin
        if (win_nxt[age[WIN_IW-1:0]] != pattern[8*i +: 8]) begin
          window_match = 1'b0;
        end
      end
    end
  end

  assign hit       = (filled_nxt >= eff_len) && window_match;
  assign too_short = (filled_nxt < eff_len) && q_item.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      filled_r    <= '0;
      line_r      <= LINE_W'(1);
      col_r       <= COL_W'(1);
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else if (take) begin
      out_valid_r <= hit || too_short;
      if (q_item.last) begin
        filled_r <= '0;
        line_r   <= LINE_W'(1);
        col_r    <= COL_W'(1);
        for (int k = 0; k < MAX_PATTERN; k++) begin
          win_r[k] <= '0;
        end
      end else begin
        filled_r <= filled_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        win_r    <= win_nxt;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (hit) begin
        out_kind_r  <= KIND_MATCH;
        out_line_r  <= line_nxt;
        out_index_r <= {1'b0, col_nxt} - INDEX_W'(eff_len);
      end else begin
        out_kind_r  <= KIND_SHORT;
        out_line_r  <= '0;
        out_index_r <= '0;
      end
    end
  end

endmodule

@@ hdl/byte_pattern_finder_line_column_core.sv @@
// ----------------------------------------------------------------------------
// byte_pattern_finder_line_column_core: streaming pattern search with position
// Scans a byte stream for a pattern of up to 16 bytes and reports line/index.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one text byte per beat in in_tdata; in_tlast marks
//   the final byte of a stream, after which window and counters start over.
//   The out_ stream gives at most one result beat per input beat. out_tuser
//   is the result kind: low for a match, high for a stream that ended before
//   the pattern fit. out_tdata holds the line number and the signed index
//   (column minus pattern length); both are zero for a too-short result.
//   The pattern and its length are set over the APB-style cfg_ port; the user
//   must set them only while no stream beat is in flight; nothing enforces it.
// Timing:
//   One byte per cycle sustained while out_tready does not hold a result.
//   An accepted byte is first written into the front queue; the compare
//   then reads it from the queue head and loads the output register that
//   feeds out_, where its result is presented. The window shift and compare
//   set the rate.
// Reset and stall:
//   rst_n (synchronous) empties the queue, drops any pending result, sets the
//   pattern to zero with length one and restarts the counters. When out_tready
//   is held low the compare stage stops and the two-entry queue fills, after
//   which in_tready falls; nothing is dropped.
// ----------------------------------------------------------------------------
module byte_pattern_finder_line_column_core import bpfl_pkg::*; #(
  parameter int MAX_PATTERN = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,   // end_of_stream
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // [31:0] line_number, [56:32] match_index
  output logic              out_tuser,  // result_kind
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  bpfl_cfg_t          cfg_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic               q_valid, q_ready;
  bpfl_item_t         q_item;
  logic               res_kind;
  logic [LINE_W-1:0]  res_line;
  logic [INDEX_W-1:0] res_index;

  // Registers lie at 8-byte strides, so the index sits above the byte offset.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_lo  <= '0;
      cfg_r.pat_hi  <= '0;
      cfg_r.pat_len <= LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAT_LO:  cfg_r.pat_lo  <= cfg_pwdata;
        REG_PAT_HI:  cfg_r.pat_hi  <= cfg_pwdata;
        REG_PAT_LEN: cfg_r.pat_len <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAT_LO:  cfg_prdata = cfg_r.pat_lo;
      REG_PAT_HI:  cfg_prdata = cfg_r.pat_hi;
      REG_PAT_LEN: cfg_prdata = {{(CFG_DW-LEN_W){1'b0}}, cfg_r.pat_len};
      default:     cfg_prdata = '0;
    endcase
  end

  // Front: accept and classify bytes into the decoupling queue.
  bpfl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Back: counters, window, compare and the result register.
  bpfl_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (res_kind),
    .out_line  (res_line),
    .out_index (res_index)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {{(64-LINE_W-INDEX_W){1'b0}}, res_index, res_line};

  // A too-short result carries no position.
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("too-short result with nonzero position");

  // A match always reports a line number of at least one.
  a_match_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] != 32'd0)
    else $error("match result with line number zero");

  // The queue can only fill while a result waits at the output.
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without a pending result");

endmodule
